/* sv/segment_weighted_vote_classifier_top_assert.svh */
// Assertion macros for the segment weighted vote classifier.
`ifndef SEGMENT_WEIGHTED_VOTE_CLASSIFIER_TOP_ASSERT_SVH
`define SEGMENT_WEIGHTED_VOTE_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked property, ignored while reset is asserted.
`define SWVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never hold at a clock edge.
`define SWVC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SWVC_ASSERT(label, prop, msg)
`define SWVC_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* sv/swvc_pkg.sv */
// Shared types, constants and codes of the segment weighted vote classifier.
package swvc_pkg;

  // Storage sizes
  localparam int MAX_ROWS     = 1024;
  localparam int MAX_SEGMENTS = 1024;
  localparam int ROW_AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SEG_AW       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // Field widths
  localparam int WEIGHT_W = 24;
  localparam int SUM_W    = 48;
  localparam int COUNT_W  = 23;
  localparam int ACTIVE_W = 11;

  localparam logic [COUNT_W-1:0]  COUNT_MAX      = {COUNT_W{1'b1}};
  localparam logic [ACTIVE_W-1:0] ACTIVE_SEG_RST = ACTIVE_W'(1024);

  // Configuration port
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_ACTIVE_SEGMENTS = 2'd0;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_LOAD     = 2'd1,
    OP_PIXEL    = 2'd2,
    OP_CLASSIFY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CLS_SKY      = 2'd0,
    CLS_GROUND   = 2'd1,
    CLS_VERTICAL = 2'd2,
    CLS_EMPTY    = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PIXEL,
    ST_CLASSIFY
  } ctrl_state_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic [9:0]                 row_index;
    logic [9:0]                 segment_label;
    logic signed [WEIGHT_W-1:0] sky_weight;
    logic signed [WEIGHT_W-1:0] ground_weight;
    logic signed [WEIGHT_W-1:0] vertical_weight;
  } item_t;

  typedef struct packed {
    class_e     segment_class;
    logic [9:0] segment_id;
  } result_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] sky;
    logic signed [WEIGHT_W-1:0] ground;
    logic signed [WEIGHT_W-1:0] vertical;
  } row_entry_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sky_sum;
    logic signed [SUM_W-1:0] ground_sum;
    logic signed [SUM_W-1:0] vertical_sum;
    logic [COUNT_W-1:0]      count;
  } acc_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic row_we;      // write row weights from the input item
    logic cnt_clr;     // restart the sweep counter
    logic acc_clr_we;  // zero the accumulator entry at the sweep counter
    logic acc_pix_we;  // write back the updated pixel accumulators
    logic res_cap;     // register the classification result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_all;     // sweep counter at the final segment
    logic last_active;  // sweep counter at the final active segment
    logic bound_zero;   // no active segments to clear
  } ctrl_status_t;

endpackage

/* sv/segment_weighted_vote_classifier_top.sv */
// Top level of the segment weighted vote classifier.
//
// Usage: drive an item on item_i and raise start; the item is taken at a
// clock edge where start is high and busy is low. Opcodes:
//   clear    - zeroes segments 0..active_segments-1, capped at MAX_SEGMENTS, busy high
//   load     - stores the row's three weights, busy stays low
//   pixel    - adds the row weights to the segment (read, then write back)
//   classify - reads the segment's accumulators, then registers the vote;
//              result_valid_o is high for one cycle, with result_o holding
//              the class
// Pixel and classify raise busy because the accumulator RAM is read
// through its registered port; pixel writes it back on the following edge.
// The receiver cannot stall: result_valid_o is high for one cycle only.
// Configuration: APB register active_segments at byte address 0, pready
// always high; write it only while busy is low and no result is pending.
// Reset: active_segments returns to 1024 and a clearing pass zeroes all
// MAX_SEGMENTS accumulator entries, one a cycle, with busy high; APB
// writes are taken during the pass. Row weights are undefined until
// loaded.
`include "segment_weighted_vote_classifier_top_assert.svh"

module segment_weighted_vote_classifier_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  swvc_pkg::item_t               item_i,
  output logic                          result_valid_o,
  output swvc_pkg::result_t             result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swvc_pkg::APB_AW-1:0]   paddr,
  input  logic [swvc_pkg::APB_DW-1:0]   pwdata,
  output logic [swvc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import swvc_pkg::*;

  logic [ACTIVE_W-1:0] active_segments_q;
  ctrl_cmd_t           cmd;
  ctrl_status_t        status;
  logic                cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_ACTIVE_SEGMENTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_segments_q <= ACTIVE_SEG_RST;
    end else if (cfg_wr) begin
      active_segments_q <= pwdata[ACTIVE_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_ACTIVE_SEGMENTS) ? APB_DW'(active_segments_q) : '0;

  // Controller
  swvc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_i.opcode),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Datapath
  swvc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (item_i),
    .active_segments_i (active_segments_q),
    .cmd_i             (cmd),
    .status_o          (status),
    .result_o          (result_o),
    .result_valid_o    (result_valid_o)
  );

  // Checks
  `SWVC_ASSERT(a_cls_latency, (start && !busy && item_i.opcode == OP_CLASSIFY) |-> ##2 result_valid_o, "classify result not two cycles after accept")
  `SWVC_ASSERT(a_pixel_busy, (start && !busy && item_i.opcode == OP_PIXEL) |=> busy, "pixel transaction did not hold busy")
  `SWVC_ASSERT_NEVER(a_acc_write_clash, cmd.acc_clr_we && cmd.acc_pix_we, "clear and pixel writes collide")

endmodule

/* sv/swvc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module swvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/swvc_ctrl.sv */
// Controller state machine: sequences init sweep, clear, load, pixel and classify.
module swvc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  swvc_pkg::opcode_e      opcode_i,
  input  swvc_pkg::ctrl_status_t status_i,
  output swvc_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy_o
);
  import swvc_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register; reset starts the accumulator clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.acc_clr_we = 1'b1;
        if (status_i.last_all) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          case (opcode_i)
            OP_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
              if (!status_i.bound_zero) begin
                state_d = ST_CLEAR;
              end
            end
            OP_LOAD: begin
              cmd_o.row_we = 1'b1;
            end
            OP_PIXEL: begin
              state_d = ST_PIXEL;
            end
            OP_CLASSIFY: begin
              state_d = ST_CLASSIFY;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.acc_clr_we = 1'b1;
        if (status_i.last_active) begin
          state_d = ST_IDLE;
        end
      end
      ST_PIXEL: begin
        cmd_o.acc_pix_we = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_CLASSIFY: begin
        cmd_o.res_cap = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* sv/swvc_datapath.sv */
// Datapath: row weight RAM, accumulator RAM, sweep counter, update and vote logic.
module swvc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  swvc_pkg::item_t                      item_i,
  input  logic [swvc_pkg::ACTIVE_W-1:0]        active_segments_i,
  input  swvc_pkg::ctrl_cmd_t                  cmd_i,
  output swvc_pkg::ctrl_status_t               status_o,
  output swvc_pkg::result_t                    result_o,
  output logic                                 result_valid_o
);
  import swvc_pkg::*;

  item_t       item_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] clr_bound;
  result_t     res_q, res_d;
  logic        res_valid_q;

  row_entry_t  row_wdata, row_rdata;
  acc_entry_t  acc_rdata, acc_wdata, acc_upd;
  logic        row_we;
  logic        acc_we;
  logic [SEG_AW-1:0] acc_waddr;
  logic        in_row_ok;
  logic        row_ok, seg_ok, pix_ok;

  // Captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
  end

  // Clear bound saturates at the number of segments
  always_comb begin
    if (int'(active_segments_i) > MAX_SEGMENTS) begin
      clr_bound = CNT_W'(MAX_SEGMENTS);
    end else begin
      clr_bound = CNT_W'(active_segments_i);
    end
  end

  // Sweep counter for the reset pass and clear items
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.acc_clr_we) begin
      cnt_d = CNT_W'(cnt_q + CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign status_o.last_all    = (cnt_q == CNT_W'(MAX_SEGMENTS - 1));
  assign status_o.last_active = (cnt_q == CNT_W'(clr_bound - CNT_W'(1)));
  assign status_o.bound_zero  = (clr_bound == '0);

  // Row weight table, written by load items straight from the input
  assign in_row_ok = (int'(item_i.row_index) < MAX_ROWS);
  assign row_we    = cmd_i.row_we && in_row_ok;
  assign row_wdata = '{sky:      item_i.sky_weight,
                       ground:   item_i.ground_weight,
                       vertical: item_i.vertical_weight};

  swvc_ram #(
    .WIDTH ($bits(row_entry_t)),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (ROW_AW'(item_i.row_index)),
    .wdata_i (row_wdata),
    .raddr_i (ROW_AW'(item_i.row_index)),
    .rdata_o (row_rdata)
  );

  // Pixel update: add the row weights, bump the count
  assign row_ok = (int'(item_q.row_index) < MAX_ROWS);
  assign seg_ok = (int'(item_q.segment_label) < MAX_SEGMENTS);
  assign pix_ok = row_ok && seg_ok && (acc_rdata.count != COUNT_MAX);

  always_comb begin
    acc_upd.sky_sum      = acc_rdata.sky_sum + SUM_W'(row_rdata.sky);
    acc_upd.ground_sum   = acc_rdata.ground_sum + SUM_W'(row_rdata.ground);
    acc_upd.vertical_sum = acc_rdata.vertical_sum + SUM_W'(row_rdata.vertical);
    acc_upd.count        = COUNT_W'(acc_rdata.count + COUNT_W'(1));
  end

  // Accumulator write: zero during sweeps, update after a pixel read
  always_comb begin
    if (cmd_i.acc_clr_we) begin
      acc_we    = 1'b1;
      acc_waddr = cnt_q[SEG_AW-1:0];
      acc_wdata = '0;
    end else begin
      acc_we    = cmd_i.acc_pix_we && pix_ok;
      acc_waddr = SEG_AW'(item_q.segment_label);
      acc_wdata = acc_upd;
    end
  end

  swvc_ram #(
    .WIDTH ($bits(acc_entry_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (SEG_AW'(item_i.segment_label)),
    .rdata_o (acc_rdata)
  );

  // Vote: vertical wins ties, ground beats sky
  always_comb begin
    res_d.segment_id = item_q.segment_label;
    if (!seg_ok || (acc_rdata.count == '0)) begin
      res_d.segment_class = CLS_EMPTY;
    end else if ((acc_rdata.vertical_sum >= acc_rdata.sky_sum) &&
                 (acc_rdata.vertical_sum >= acc_rdata.ground_sum)) begin
      res_d.segment_class = CLS_VERTICAL;
    end else if ((acc_rdata.ground_sum >= acc_rdata.vertical_sum) &&
                 (acc_rdata.ground_sum >= acc_rdata.sky_sum)) begin
      res_d.segment_class = CLS_GROUND;
    end else begin
      res_d.segment_class = CLS_SKY;
    end
  end

  // Result register and one-cycle strobe
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_cap) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_cap;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule
